/* hdl/sor_pkg.sv */
// shared types and constants for the spiral order matrix reader
`timescale 1ns / 1ps

package sor_pkg;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CMD_W       = 2;
    localparam int ELEM_W      = 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;

    // largest count a configuration register can hold
    localparam int CFG_MAX = (2 ** CFG_DATA_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_ZERO  = 2'd2,
        OP_EMPTY = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     layer_end;
        logic     last;
    } op_ctl_t;

    localparam int OP_CTL_W = $bits(op_ctl_t);

endpackage

/* hdl/spiral_order_matrix_reader.sv */
// top level of the spiral order matrix reader
//
//   channel   direction  handshake                  payload
//   s_*       in         s_valid / s_ready          s_command, s_element_in
//   m_*       out        m_valid / m_ready          m_element_out, m_layer_end,
//                                                   m_last, m_empty_res
//   cfg_*     in         cfg_wr_en (no wait)        cfg_index, cfg_wr_data
//
// one command per cycle sustained while the queue is not full; a fetch result is
// registered first in the op queue, then in the result register that takes the
// registered memory read. aresetn clears pointers, walk state, queue and the
// result valid; the matrix memory holds garbage until loaded, with no clearing
// pass. a stalled result fills the two-entry queue, after which s_ready drops;
// loads still drain to memory behind a stalled result.
`timescale 1ns / 1ps

module spiral_order_matrix_reader import sor_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic signed [ELEM_W-1:0] s_element_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ELEM_W-1:0] m_element_out,
    output logic                     m_layer_end,
    output logic                     m_last,
    output logic                     m_empty_res
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Q_W    = OP_CTL_W + ADDR_W + ELEM_W;

    logic              push, full, pop, head_valid;
    op_ctl_t           push_ctl, head_ctl;
    logic [ADDR_W-1:0] push_addr, head_addr;
    logic [ELEM_W-1:0] push_data, head_data;
    logic [Q_W-1:0]    q_in, q_head;

    sor_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_element_in (s_element_in),
        .q_full       (full),
        .q_push       (push),
        .q_ctl        (push_ctl),
        .q_addr       (push_addr),
        .q_data       (push_data)
    );

    assign q_in = {push_ctl, push_addr, push_data};

    sor_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (pop),
        .valid     (head_valid),
        .head      (q_head)
    );

    assign {head_ctl, head_addr, head_data} = q_head;

    sor_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (head_valid),
        .q_ctl         (head_ctl),
        .q_addr        (head_addr),
        .q_data        (head_data),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_out (m_element_out),
        .m_layer_end   (m_layer_end),
        .m_last        (m_last),
        .m_empty_res   (m_empty_res)
    );

endmodule

/* hdl/sor_front.sv */
// front end: accepts commands, tracks load pointer and spiral walk, issues ops
`timescale 1ns / 1ps

module sor_front import sor_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int ADDR_W   = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic signed [ELEM_W-1:0] s_element_in,
    input  logic                     q_full,
    output logic                     q_push,
    output op_ctl_t                  q_ctl,
    output logic [ADDR_W-1:0]        q_addr,
    output logic [ELEM_W-1:0]        q_data
);

    localparam int EFF_R   = (MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS;
    localparam int EFF_C   = (MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS;
    localparam int CNT_W   = $clog2(EFF_R * EFF_C + 1);
    localparam int POS_W   = CNT_W + 3;
    localparam int RIDX_W  = (EFF_R > 1) ? $clog2(EFF_R) : 1;
    localparam int CIDX_W  = (EFF_C > 1) ? $clog2(EFF_C) : 1;
    localparam int PROD_W  = 2 * CFG_DATA_W;

    localparam logic signed [POS_W-1:0] ZERO_S = '0;
    localparam logic signed [POS_W-1:0] ONE_S  = POS_W'(1);

    logic [CFG_DATA_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [CFG_DATA_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]        load_ptr_reg, load_ptr_next;
    logic [CNT_W-1:0]        emitted_reg, emitted_next;
    logic [CNT_W-1:0]        layer_reg, layer_next;
    dir_t                    dir_reg, dir_next;
    logic signed [POS_W-1:0] row_reg, row_next;
    logic signed [POS_W-1:0] col_reg, col_next;

    logic [CFG_DATA_W-1:0]   rows_eff, cols_eff;
    logic [PROD_W-1:0]       total_prod;
    logic [CNT_W-1:0]        total;
    logic signed [POS_W-1:0] rows_s, cols_s, layer_s, bottom_s, right_s;
    logic                    accept, load_ok, walk_done, pos_ok, is_final;
    logic [RIDX_W-1:0]       row_idx;
    logic [CIDX_W-1:0]       col_idx;
    logic [ADDR_W-1:0]       read_addr;
    cmd_t                    cmd;

    // spiral step results
    logic [CNT_W-1:0]        step_layer;
    dir_t                    step_dir;
    logic signed [POS_W-1:0] step_row, step_col;
    logic                    step_closed;

    assign cmd    = cmd_t'(s_command);
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // zero counts as one, oversize clamps to the array size
    assign rows_eff = (row_cnt_reg == '0) ? CFG_DATA_W'(1) :
                      (int'(row_cnt_reg) > EFF_R) ? CFG_DATA_W'(EFF_R) : row_cnt_reg;
    assign cols_eff = (col_cnt_reg == '0) ? CFG_DATA_W'(1) :
                      (int'(col_cnt_reg) > EFF_C) ? CFG_DATA_W'(EFF_C) : col_cnt_reg;

    assign total_prod = PROD_W'(rows_eff) * PROD_W'(cols_eff);
    assign total      = CNT_W'(total_prod);

    assign load_ok   = load_ptr_reg < total;
    assign walk_done = emitted_reg >= total;
    assign is_final  = (emitted_reg + CNT_W'(1)) >= total;

    assign rows_s   = POS_W'(rows_eff);
    assign cols_s   = POS_W'(cols_eff);
    assign layer_s  = POS_W'(layer_reg);
    assign bottom_s = rows_s - layer_s - ONE_S;
    assign right_s  = cols_s - layer_s - ONE_S;

    assign pos_ok = (row_reg >= ZERO_S) && (col_reg >= ZERO_S) &&
                    (row_reg < rows_s) && (col_reg < cols_s);

    assign row_idx   = RIDX_W'(row_reg);
    assign col_idx   = CIDX_W'(col_reg);
    assign read_addr = ADDR_W'(row_idx) * ADDR_W'(cols_eff) + ADDR_W'(col_idx);

    // one step along the clockwise spiral
    always_comb begin
        step_layer  = layer_reg;
        step_dir    = dir_reg;
        step_row    = row_reg;
        step_col    = col_reg;
        step_closed = 1'b0;
        case (dir_reg)
            DIR_RIGHT: begin
                if (col_reg < right_s) begin
                    step_col = col_reg + ONE_S;
                end else begin
                    step_dir = DIR_DOWN;
                    step_row = row_reg + ONE_S;
                end
            end
            DIR_DOWN: begin
                if (row_reg < bottom_s) begin
                    step_row = row_reg + ONE_S;
                end else begin
                    step_dir = DIR_LEFT;
                    step_col = col_reg - ONE_S;
                end
            end
            DIR_LEFT: begin
                if (col_reg > layer_s) begin
                    step_col = col_reg - ONE_S;
                end else begin
                    step_dir = DIR_UP;
                    step_row = row_reg - ONE_S;
                end
            end
            default: begin
                if (row_reg > layer_s + ONE_S) begin
                    step_row = row_reg - ONE_S;
                end else begin
                    step_layer  = layer_reg + CNT_W'(1);
                    step_dir    = DIR_RIGHT;
                    step_row    = layer_s + ONE_S;
                    step_col    = layer_s + ONE_S;
                    step_closed = 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        load_ptr_next = load_ptr_reg;
        emitted_next  = emitted_reg;
        layer_next    = layer_reg;
        dir_next      = dir_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_COUNT: row_cnt_next = cfg_wr_data;
                REG_COL_COUNT: col_cnt_next = cfg_wr_data;
                default: ;
            endcase
        end
        if (accept) begin
            case (cmd)
                CMD_LOAD: begin
                    if (load_ok) begin
                        load_ptr_next = load_ptr_reg + CNT_W'(1);
                    end
                end
                CMD_FETCH: begin
                    if (!walk_done) begin
                        emitted_next = emitted_reg + CNT_W'(1);
                        layer_next   = step_layer;
                        dir_next     = step_dir;
                        row_next     = step_row;
                        col_next     = step_col;
                    end
                end
                CMD_CLEAR: begin
                    load_ptr_next = '0;
                    emitted_next  = '0;
                    layer_next    = '0;
                    dir_next      = DIR_RIGHT;
                    row_next      = ZERO_S;
                    col_next      = ZERO_S;
                end
                default: ;
            endcase
        end
    end

    // op issued to the back end
    always_comb begin
        q_push          = 1'b0;
        q_ctl.kind      = OP_WRITE;
        q_ctl.layer_end = 1'b0;
        q_ctl.last      = 1'b0;
        q_addr          = ADDR_W'(load_ptr_reg);
        q_data          = s_element_in;
        if (accept) begin
            case (cmd)
                CMD_LOAD: begin
                    q_push = load_ok;
                end
                CMD_FETCH: begin
                    q_push = 1'b1;
                    if (walk_done) begin
                        q_ctl.kind = OP_EMPTY;
                    end else begin
                        q_ctl.kind      = pos_ok ? OP_READ : OP_ZERO;
                        q_ctl.layer_end = step_closed && !is_final;
                        q_ctl.last      = is_final;
                        q_addr          = read_addr;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= CFG_DATA_W'(1);
            col_cnt_reg  <= CFG_DATA_W'(1);
            load_ptr_reg <= '0;
            emitted_reg  <= '0;
            layer_reg    <= '0;
            dir_reg      <= DIR_RIGHT;
            row_reg      <= ZERO_S;
            col_reg      <= ZERO_S;
        end else begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            load_ptr_reg <= load_ptr_next;
            emitted_reg  <= emitted_next;
            layer_reg    <= layer_next;
            dir_reg      <= dir_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

endmodule

/* hdl/sor_queue.sv */
// two-entry op queue between the front end and the back end
`timescale 1ns / 1ps

module sor_queue import sor_pkg::*; #(
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] head
);

    logic [DATA_W-1:0]  entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    assign full  = count_reg == (Q_PTR_W + 1)'(Q_DEPTH);
    assign valid = count_reg != '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/sor_back.sv */
// back end: matrix memory, element reads and the result register
`timescale 1ns / 1ps

module sor_back import sor_pkg::*; #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  op_ctl_t                  q_ctl,
    input  logic [ADDR_W-1:0]        q_addr,
    input  logic [ELEM_W-1:0]        q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ELEM_W-1:0] m_element_out,
    output logic                     m_layer_end,
    output logic                     m_last,
    output logic                     m_empty_res
);

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;
    logic              out_valid_reg, out_valid_next;
    op_ctl_t           out_ctl_reg, out_ctl_next;
    logic              is_write;

    assign is_write = q_ctl.kind == OP_WRITE;

    // writes never wait on the result side
    assign q_pop = q_valid && (is_write || !out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_ctl_next   = out_ctl_reg;
        if (q_pop && !is_write) begin
            out_valid_next = 1'b1;
            out_ctl_next   = q_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_write) begin
            mem[q_addr] <= q_data;
        end
        if (q_pop && q_ctl.kind == OP_READ) begin
            rdata_reg <= mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        out_ctl_reg <= out_ctl_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_element_out = (out_ctl_reg.kind == OP_READ) ? rdata_reg : '0;
    assign m_layer_end   = out_ctl_reg.layer_end;
    assign m_last        = out_ctl_reg.last;
    assign m_empty_res   = out_ctl_reg.kind == OP_EMPTY;

endmodule

/* tb/sv/tb_spiral_order_matrix_reader.sv */
// self-checking testbench for the spiral order matrix reader: random load/fetch/clear traffic
`timescale 1ns / 1ps

module tb_spiral_order_matrix_reader import sor_pkg::*;;

    localparam int MAX_DIM         = 64;
    localparam int STORE_WORDS     = MAX_DIM * MAX_DIM;
    localparam int CTX_PLAN        = 0;
    localparam int CTX_DUT         = 1;
    localparam int IDLE_PCT        = 14;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEM_TARGET     = 1550;
    localparam int LOAD_CAP        = 96;
    localparam int FETCH_CAP       = 160;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] data;
    } matrix_cmd_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     layer_end;
        logic                     last;
        logic                     empty_res;
    } spiral_read_t;

    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    cfg_wr_data  = '0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command    = '0;
    logic signed [ELEM_W-1:0] s_element_in = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [ELEM_W-1:0] m_element_out;
    logic                     m_layer_end;
    logic                     m_last;
    logic                     m_empty_res;

    spiral_order_matrix_reader dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_element_in  (s_element_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_out (m_element_out),
        .m_layer_end   (m_layer_end),
        .m_last        (m_last),
        .m_empty_res   (m_empty_res)
    );

    always #5 aclk = ~aclk;

    // two shadow copies: one for planning stimulus, one advanced on accepted transactions
    logic [ELEM_W-1:0]     mat_store [2][STORE_WORDS];
    logic [CFG_DATA_W-1:0] row_cfg [2];
    logic [CFG_DATA_W-1:0] col_cfg [2];
    int                    load_ptr [2];
    int                    layer_idx [2];
    dir_t                  walk_dir [2];
    int                    walk_row [2];
    int                    walk_col [2];
    int                    emitted [2];

    matrix_cmd_t  pending_cmds [$];
    spiral_read_t expected_reads [$];
    int           planned_items  = 0;
    int           mismatches     = 0;
    int           cyc            = 0;
    int           stall_cycles   = 0;
    int           hold_left      = 0;
    bit           hold_off_req   = 1'b0;
    bit           hold_off_taken = 1'b0;
    wire          calm = (cyc >= 800) && (cyc < 1600);

    function automatic int clamp_count(input logic [CFG_DATA_W-1:0] n);
        if (n == 0) return 1;
        if (n > MAX_DIM) return MAX_DIM;
        return int'(n);
    endfunction

    function automatic void rewind_walk(input int c);
        layer_idx[c] = 0;
        walk_dir[c]  = DIR_RIGHT;
        walk_row[c]  = 0;
        walk_col[c]  = 0;
        emitted[c]   = 0;
    endfunction

    function automatic void shadow_reset(input int c);
        for (int i = 0; i < STORE_WORDS; i++) mat_store[c][i] = 'x;
        row_cfg[c]  = CFG_DATA_W'(1);
        col_cfg[c]  = CFG_DATA_W'(1);
        load_ptr[c] = 0;
        rewind_walk(c);
    endfunction

    // element under the walk position; outside the matrix reads as zero
    function automatic logic [ELEM_W-1:0] spiral_peek(input int c);
        int rows, cols;
        rows = clamp_count(row_cfg[c]);
        cols = clamp_count(col_cfg[c]);
        if (walk_row[c] >= 0 && walk_col[c] >= 0 && walk_row[c] < rows && walk_col[c] < cols)
            return mat_store[c][walk_row[c] * cols + walk_col[c]];
        return '0;
    endfunction

    // steps one position clockwise, returns 1 when a layer closes
    function automatic bit walk_advance(input int c, input int rows, input int cols);
        int top, bottom, right;
        top    = layer_idx[c];
        bottom = rows - 1 - top;
        right  = cols - 1 - top;
        case (walk_dir[c])
            DIR_RIGHT: begin
                if (walk_col[c] < right) walk_col[c] = walk_col[c] + 1;
                else begin
                    walk_dir[c] = DIR_DOWN;
                    walk_row[c] = walk_row[c] + 1;
                end
            end
            DIR_DOWN: begin
                if (walk_row[c] < bottom) walk_row[c] = walk_row[c] + 1;
                else begin
                    walk_dir[c] = DIR_LEFT;
                    walk_col[c] = walk_col[c] - 1;
                end
            end
            DIR_LEFT: begin
                if (walk_col[c] > top) walk_col[c] = walk_col[c] - 1;
                else begin
                    walk_dir[c] = DIR_UP;
                    walk_row[c] = walk_row[c] - 1;
                end
            end
            default: begin
                if (walk_row[c] > top + 1) walk_row[c] = walk_row[c] - 1;
                else begin
                    layer_idx[c] = layer_idx[c] + 1;
                    walk_dir[c]  = DIR_RIGHT;
                    walk_row[c]  = layer_idx[c];
                    walk_col[c]  = layer_idx[c];
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // applies one command to a shadow copy; returns 1 when it yields a result
    function automatic bit spiral_step(input int c, input matrix_cmd_t item,
                                       output spiral_read_t res, output bit active);
        int rows, cols, total;
        bit last_elem, closed;
        rows   = clamp_count(row_cfg[c]);
        cols   = clamp_count(col_cfg[c]);
        total  = rows * cols;
        res    = '0;
        active = 1'b1;
        case (item.cmd)
            CMD_LOAD: begin
                if (load_ptr[c] < total) begin
                    mat_store[c][load_ptr[c]] = item.data;
                    load_ptr[c] = load_ptr[c] + 1;
                end else
                    active = 1'b0;
                return 1'b0;
            end
            CMD_CLEAR: begin
                load_ptr[c] = 0;
                rewind_walk(c);
                return 1'b0;
            end
            CMD_FETCH: begin
                if (emitted[c] >= total) begin
                    res.empty_res = 1'b1;
                    return 1'b1;
                end
                res.element   = spiral_peek(c);
                emitted[c]    = emitted[c] + 1;
                last_elem     = emitted[c] >= total;
                closed        = walk_advance(c, rows, cols);
                res.layer_end = closed && !last_elem;
                res.last      = last_elem;
                return 1'b1;
            end
            default: begin
                active = 1'b0;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // a fetch here would read a store entry that was never loaded
    function automatic bit fetch_blocked(input int c);
        int total;
        total = clamp_count(row_cfg[c]) * clamp_count(col_cfg[c]);
        return emitted[c] < total && $isunknown(spiral_peek(c));
    endfunction

    function automatic void plan_cmd(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] data);
        matrix_cmd_t  item;
        spiral_read_t ignored_res;
        bit           active;
        if (cmd == CMD_FETCH && fetch_blocked(CTX_PLAN)) return;
        item.cmd  = cmd;
        item.data = data;
        void'(spiral_step(CTX_PLAN, item, ignored_res, active));
        pending_cmds.push_back(item);
        if (active) planned_items++;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] odd_count();
        case ($urandom_range(5))
            0: return CFG_DATA_W'(0);
            1: return CFG_DATA_W'(1);
            2: return CFG_DATA_W'(63);
            3: return CFG_DATA_W'(64);
            4: return CFG_DATA_W'(65);
            default: return CFG_DATA_W'(127);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        for (int c = 0; c < 2; c++) begin
            if (idx == REG_ROW_COUNT) row_cfg[c] = val;
            else col_cfg[c] = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_reads.size() != 0)
            @(posedge aclk);
        // trailing loads or nops may still be in flight
        repeat (4) @(posedge aclk);
    endtask

    task automatic spiral_phase(input logic [CFG_DATA_W-1:0] rv, input logic [CFG_DATA_W-1:0] cv,
                                input bit clear_first, input bit noisy, input bit squeeze);
        int               total, loads, fetches;
        logic [CMD_W-1:0] cmd;
        wait_drained();
        if (rv != row_cfg[CTX_PLAN] || $urandom_range(3) == 0) write_reg(REG_ROW_COUNT, rv);
        if (cv != col_cfg[CTX_PLAN] || $urandom_range(3) == 0) write_reg(REG_COL_COUNT, cv);
        if (squeeze) hold_off_req = 1'b1;
        total = clamp_count(rv) * clamp_count(cv);
        if (clear_first) plan_cmd(CMD_CLEAR, $urandom);
        if (noisy) begin
            repeat ($urandom_range(20, 60)) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7:           cmd = CMD_LOAD;
                    8, 9, 10, 11, 12, 13, 14, 15: cmd = CMD_FETCH;
                    16:                               cmd = CMD_CLEAR;
                    default:                          cmd = CMD_NOP;
                endcase
                if (cmd == CMD_FETCH && fetch_blocked(CTX_PLAN)) cmd = CMD_LOAD;
                plan_cmd(cmd, $urandom);
            end
        end else begin
            loads   = (total > LOAD_CAP) ? LOAD_CAP : total;
            fetches = ((total > FETCH_CAP) ? FETCH_CAP : total) + $urandom_range(2);
            // broken sequences: short load or walk stopped midway
            if ($urandom_range(4) == 0) loads = $urandom_range(loads);
            if ($urandom_range(4) == 0) fetches = $urandom_range(fetches);
            repeat (loads) plan_cmd(CMD_LOAD, $urandom);
            repeat (fetches) plan_cmd(CMD_FETCH, $urandom);
        end
    endtask

    task automatic check_field(input string name, input logic signed [ELEM_W-1:0] want,
                               input logic signed [ELEM_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) cyc <= cyc + 1;

    always @(posedge aclk) begin : cmd_driver
        matrix_cmd_t  taken, nxt;
        spiral_read_t res;
        bit           active;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken.cmd  = s_command;
                taken.data = s_element_in;
                if (spiral_step(CTX_DUT, taken, res, active)) expected_reads.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_cmds.pop_front();
                    s_valid      <= 1'b1;
                    s_command    <= nxt.cmd;
                    s_element_in <= nxt.data;
                end else
                    s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        spiral_read_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $error("result with no fetch outstanding, element_out %0d", m_element_out);
                    mismatches++;
                end else begin
                    want = expected_reads.pop_front();
                    check_field("element_out", want.element, m_element_out);
                    check_field("layer_end", want.layer_end, m_layer_end);
                    check_field("last", want.last, m_last);
                    check_field("empty_res", want.empty_res, m_empty_res);
                end
            end
            if (hold_off_req && !hold_off_taken) begin
                hold_left      = HOLD_OFF_CYCLES;
                hold_off_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ends the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT) begin
            $display("** spiral_order_matrix_reader: FAILED **");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : stimulus
        int                    phase;
        logic [CFG_DATA_W-1:0] rv, cv, tmp;
        bit                    squeeze;
        shadow_reset(CTX_PLAN);
        shadow_reset(CTX_DUT);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // single element matrix: last flag, fetch past end, load past end, unused command
        plan_cmd(CMD_LOAD, 32'h8000_0000);
        plan_cmd(CMD_FETCH, 32'hFFFF_FFFF);
        plan_cmd(CMD_FETCH, 32'h0000_0000);
        plan_cmd(CMD_LOAD, 32'h7FFF_FFFF);
        plan_cmd(CMD_NOP, 32'h5555_5555);
        plan_cmd(CMD_CLEAR, 32'hAAAA_AAAA);

        // 3x3 has an inner layer, so layer_end fires once
        wait_drained();
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(3));
        write_reg(REG_COL_COUNT, CFG_DATA_W'(3));
        plan_cmd(CMD_LOAD, 32'h7FFF_FFFF);
        plan_cmd(CMD_LOAD, 32'hFFFF_FFFF);
        plan_cmd(CMD_LOAD, 32'h0000_0000);
        plan_cmd(CMD_LOAD, 32'h8000_0000);
        plan_cmd(CMD_LOAD, 32'h0000_0001);
        repeat (4) plan_cmd(CMD_LOAD, $urandom);
        repeat (10) plan_cmd(CMD_FETCH, $urandom);

        phase = 0;
        while (planned_items < ITEM_TARGET) begin
            squeeze = 1'b0;
            case (phase)
                0: begin
                    rv = CFG_DATA_W'(127);
                    cv = CFG_DATA_W'(127);
                end
                1: begin
                    rv = CFG_DATA_W'(0);
                    cv = CFG_DATA_W'(64);
                end
                2: begin
                    rv = CFG_DATA_W'(64);
                    cv = CFG_DATA_W'(0);
                end
                3: begin
                    rv      = CFG_DATA_W'(6);
                    cv      = CFG_DATA_W'(6);
                    squeeze = 1'b1;
                end
                default: begin
                    if ($urandom_range(9) == 0) begin
                        rv = odd_count();
                        cv = CFG_DATA_W'($urandom_range(1, 3));
                        if ($urandom_range(1) == 1) begin
                            tmp = rv;
                            rv  = cv;
                            cv  = tmp;
                        end
                    end else begin
                        rv = CFG_DATA_W'($urandom_range(1, 8));
                        cv = CFG_DATA_W'($urandom_range(1, 8));
                    end
                end
            endcase
            spiral_phase(rv, cv, phase < 4 || $urandom_range(4) != 0,
                         phase >= 4 && $urandom_range(4) == 0, squeeze);
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("** spiral_order_matrix_reader: PASSED **");
        else
            $display("** spiral_order_matrix_reader: FAILED **");
        $finish;
    end

endmodule
